// ===== rtl/ladf_pkg.sv =====
// Shared widths, constants and types for the four-pole ladder filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ladf_pkg;

	// field and state widths
	localparam int SAMPLE_W   = 16;
	localparam int STATE_W    = 32;
	localparam int CUT_W      = 13;
	localparam int RES_W      = 14;
	localparam int GAIN_W     = 16;
	localparam int FRAC_W     = 12;

	// serial multiplier: gain operand consumed one digit per cycle while step is asserted
	localparam int DIGIT_W    = 4;
	localparam int N_DIGITS   = GAIN_W / DIGIT_W;
	localparam int DIG_CNT_W  = $clog2(N_DIGITS);
	localparam int PROD_W     = STATE_W + GAIN_W;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESONANCE = 1'd1;

	// stream widths
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = SAMPLE_W + 2 * STATE_W;

	// arithmetic constants
	localparam int CUT_COEF = 3276;  // 0.8 in Q12
	localparam logic signed [GAIN_W-1:0]   ONE_GAIN = GAIN_W'(1 << FRAC_W);
	localparam logic signed [SAMPLE_W-1:0] S16_MAX  = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] S16_MIN  = 16'sh8000;

	typedef struct packed {
		logic signed [GAIN_W-1:0] pole;
		logic signed [GAIN_W-1:0] damp;
	} gains_t;

	typedef struct packed {
		logic load;   // latch operands, clear accumulator
		logic step;   // consume one digit of the gain operand
		logic last;   // this step takes the signed top digit
	} mul_ctl_t;

	typedef struct packed {
		logic signed [STATE_W-1:0]  bandpass;
		logic signed [STATE_W-1:0]  highpass;
		logic signed [SAMPLE_W-1:0] lowpass;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/ladf_smul.sv =====
// Digit-serial signed multiplier: 32-bit state operand times 16-bit gain.
// Depends on ladf_pkg. Four steps per product, low digits shift out into lo_q.
`default_nettype none

module ladf_smul import ladf_pkg::*; (
	input  wire logic                     clk,
	input  wire mul_ctl_t                 ctl,
	input  wire logic signed [STATE_W-1:0] a,
	input  wire logic signed [GAIN_W-1:0]  b,
	output logic signed [PROD_W-1:0]       prod
);

	localparam int PP_W = STATE_W + DIGIT_W + 1;

	logic signed [STATE_W-1:0] a_q;
	logic        [GAIN_W-1:0]  b_q;
	logic signed [STATE_W:0]   hi_q;
	logic        [GAIN_W-1:0]  lo_q;

	logic signed [DIGIT_W:0] digit;
	logic signed [PP_W-1:0]  pp;
	logic signed [PP_W-1:0]  sum;

	// top digit of a two's complement gain carries negative weight
	always_comb begin
		if (ctl.last) begin
			digit = signed'({b_q[DIGIT_W-1], b_q[DIGIT_W-1:0]});
		end else begin
			digit = signed'({1'b0, b_q[DIGIT_W-1:0]});
		end
		pp  = a_q * digit;
		sum = PP_W'(hi_q) + pp;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (ctl.step) begin
			b_q  <= b_q >> DIGIT_W;
			hi_q <= sum[PP_W-1:DIGIT_W];
			lo_q <= {sum[DIGIT_W-1:0], lo_q[GAIN_W-1:DIGIT_W]};
		end
	end

	assign prod = {hi_q[STATE_W-1:0], lo_q};

endmodule

`default_nettype wire

// ===== rtl/ladf_gain.sv =====
// Pole gain and damping derived from the cutoff register, three pipeline stages.
// Depends on ladf_pkg. busy is high while a recompute is in flight.
`default_nettype none

module ladf_gain import ladf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             we,
	input  wire logic [CUT_W-1:0] cutoff,
	output gains_t                gains,
	output logic                  busy
);

	localparam int CP_W = CUT_W + FRAC_W;
	localparam int M_W  = 2 * (CUT_W + 1);
	localparam logic [M_W-1:0] BIAS = M_W'((1 << FRAC_W) - 1);

	logic [CUT_W-1:0] cut_q;
	logic             v_s1, v_s2, v_s3;
	logic [CUT_W-1:0] t_s2;
	logic signed [CUT_W:0]   dc_s2;
	logic signed [M_W-1:0]   m_s3;
	gains_t                  gains_q;

	logic [CP_W-1:0]          coef_prod;
	logic [M_W-1:0]           m_biased;
	logic signed [GAIN_W-1:0] quot;
	logic signed [GAIN_W-1:0] pole;

	always_comb begin
		coef_prod = CP_W'(CUT_COEF) * CP_W'(cut_q);
		// truncate toward zero on the divide by 4096
		m_biased  = m_s3 + (m_s3[M_W-1] ? BIAS : '0);
		quot      = signed'(m_biased[FRAC_W+GAIN_W-1:FRAC_W]);
		pole      = signed'(GAIN_W'(cut_q)) + quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			gains_q <= '{pole: ONE_GAIN, damp: ONE_GAIN};
		end else begin
			v_s1 <= we;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				gains_q.pole <= pole;
				gains_q.damp <= (pole <<< 1) - ONE_GAIN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			cut_q <= cutoff;
		end
		t_s2  <= coef_prod[CP_W-1:FRAC_W];
		dc_s2 <= signed'((CUT_W+1)'(1 << FRAC_W) - {1'b0, cut_q});
		m_s3  <= signed'({1'b0, t_s2}) * dc_s2;
	end

	assign gains = gains_q;
	assign busy  = v_s1 | v_s2 | v_s3;

endmodule

`default_nettype wire

// ===== rtl/ladf_core.sv =====
// Filter state and sequencer: feedback, then four ladder stages, each product
// on the shared serial multiplier. Depends on ladf_pkg and ladf_smul.
`default_nettype none

module ladf_core import ladf_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic [RES_W-1:0]          resonance,
	input  wire gains_t                    gains,
	output logic                           busy,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output result_t                        res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_STEP = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	// one product per op: feedback, then pole (A) and damping (B) per stage
	localparam logic [3:0] OP_FB = 4'd0;
	localparam logic [3:0] OP_A1 = 4'd1;
	localparam logic [3:0] OP_B1 = 4'd2;
	localparam logic [3:0] OP_A2 = 4'd3;
	localparam logic [3:0] OP_B2 = 4'd4;
	localparam logic [3:0] OP_A3 = 4'd5;
	localparam logic [3:0] OP_B3 = 4'd6;
	localparam logic [3:0] OP_A4 = 4'd7;
	localparam logic [3:0] OP_B4 = 4'd8;

	localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(N_DIGITS - 1);
	localparam logic [PROD_W-1:0]    BIAS     = PROD_W'((1 << FRAC_W) - 1);

	logic [2:0]           state_q;
	logic [3:0]           op_q;
	logic [DIG_CNT_W-1:0] dig_q;

	logic signed [SAMPLE_W-1:0] smp_q;
	logic signed [STATE_W-1:0]  fed_q, st1_q, st2_q, st3_q;
	logic signed [SAMPLE_W-1:0] st4_q;
	logic signed [STATE_W-1:0]  cur_q, prev_q, a_q;

	mul_ctl_t                  mctl;
	logic signed [STATE_W-1:0] mul_a;
	logic signed [GAIN_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  prod;

	logic [PROD_W-1:0]          prod_biased;
	logic signed [STATE_W-1:0]  quot;
	logic signed [STATE_W-1:0]  nv;
	logic signed [STATE_W-1:0]  xin;
	logic signed [SAMPLE_W-1:0] nv_clip;
	logic signed [STATE_W-1:0]  s4_wide;
	logic signed [STATE_W-1:0]  bp_diff;

	// operand select
	always_comb begin
		unique case (op_q)
			OP_FB: begin
				mul_a = STATE_W'(st4_q);
				mul_b = signed'(GAIN_W'(resonance));
			end
			OP_A1, OP_A2, OP_A3, OP_A4: begin
				mul_a = cur_q + prev_q;
				mul_b = gains.pole;
			end
			OP_B1: begin
				mul_a = st1_q;
				mul_b = gains.damp;
			end
			OP_B2: begin
				mul_a = st2_q;
				mul_b = gains.damp;
			end
			OP_B3: begin
				mul_a = st3_q;
				mul_b = gains.damp;
			end
			OP_B4: begin
				mul_a = STATE_W'(st4_q);
				mul_b = gains.damp;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mctl.load = (state_q == ST_LOAD);
	assign mctl.step = (state_q == ST_STEP);
	assign mctl.last = (state_q == ST_STEP) && (dig_q == DIG_LAST);

	ladf_smul u_smul (
		.clk  (clk),
		.ctl  (mctl),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// product / 4096 toward zero, kept to 32 bits; stage result and clip
	always_comb begin
		prod_biased = prod + (prod[PROD_W-1] ? BIAS : '0);
		quot        = signed'(prod_biased[FRAC_W+STATE_W-1:FRAC_W]);
		nv          = a_q - quot;
		xin         = STATE_W'(smp_q) - quot;
		if ((&nv[STATE_W-1:SAMPLE_W-1]) || !(|nv[STATE_W-1:SAMPLE_W-1])) begin
			nv_clip = nv[SAMPLE_W-1:0];
		end else if (nv[STATE_W-1]) begin
			nv_clip = S16_MIN;
		end else begin
			nv_clip = S16_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_FB;
			dig_q   <= '0;
			fed_q   <= '0;
			st1_q   <= '0;
			st2_q   <= '0;
			st3_q   <= '0;
			st4_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q    <= OP_FB;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					dig_q   <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					dig_q <= dig_q + 1'b1;
					if (dig_q == DIG_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					unique case (op_q)
						OP_FB:   fed_q <= xin;
						OP_B1:   st1_q <= nv;
						OP_B2:   st2_q <= nv;
						OP_B3:   st3_q <= nv;
						OP_B4:   st4_q <= nv_clip;
						default: ;
					endcase
					if (op_q == OP_B4) begin
						state_q <= ST_EMIT;
					end else begin
						op_q    <= op_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// scratch: cur/prev feed the next stage's input sum (new + old)
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			smp_q <= sample;
		end
		if (state_q == ST_DONE) begin
			unique case (op_q)
				OP_FB: begin
					prev_q <= fed_q;
					cur_q  <= xin;
				end
				OP_A1, OP_A2, OP_A3, OP_A4: a_q <= quot;
				OP_B1: begin
					prev_q <= st1_q;
					cur_q  <= nv;
				end
				OP_B2: begin
					prev_q <= st2_q;
					cur_q  <= nv;
				end
				OP_B3: begin
					prev_q <= st3_q;
					cur_q  <= nv;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		s4_wide      = STATE_W'(st4_q);
		bp_diff      = st3_q - s4_wide;
		res.lowpass  = st4_q;
		res.highpass = fed_q - s4_wide;
		res.bandpass = bp_diff + signed'({bp_diff[STATE_W-2:0], 1'b0});
	end

	assign res_valid = (state_q == ST_EMIT);
	assign busy      = (state_q != ST_IDLE);

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("item started while sequencer busy");

	a_emit_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> op_q == OP_B4)
		else $error("result shown before last stage finished");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && dig_q == DIG_LAST) |=> state_q == ST_DONE)
		else $error("multiplier digit count broken");
`endif

endmodule

`default_nettype wire

// ===== rtl/four_pole_ladder_filter_top.sv =====
// Top level of the resonant four-pole ladder low-pass filter (Q12).
// Depends on ladf_pkg, ladf_gain, ladf_core (and ladf_smul below it).
//
//   channel   dir  handshake              payload
//   s_axis    in   s_axis_tvalid/tready   tdata[15:0]  sample
//   m_axis    out  m_axis_tvalid/tready   tdata[79:0]  lowpass, highpass, bandpass
//   cfg       in   cfg_we                 cfg_index, cfg_data
//
// Each item runs nine products (feedback, then pole and damping terms of
// four stages) on one 32x4 digit-serial multiplier; each product is loaded,
// stepped digit by digit and written back, between accept and hand-off.
// The next item is taken while a result waits in the output register.
// A cutoff write recomputes the gains in the ladf_gain pipeline; input is held off meanwhile.
// Reset (arst_n low) clears filter state, resonance to 0, gains to cutoff 4096.
`default_nettype none

module four_pole_ladder_filter_top import ladf_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// slave stream
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
	// master stream
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [15:0] lowpass, [47:16] highpass,
	                                                    // [79:48] bandpass
	// configuration writes
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [RES_W-1:0] resonance_q;
	gains_t           gains;
	logic             gain_busy;
	logic             core_busy;
	logic             start;
	logic             res_valid;
	logic             res_ready;
	result_t          res;
	logic             out_valid_q;
	result_t          out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resonance_q <= '0;
		end else if (cfg_we && cfg_index == REG_RESONANCE) begin
			resonance_q <= cfg_data[RES_W-1:0];
		end
	end

	ladf_gain u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we && cfg_index == REG_CUTOFF),
		.cutoff (cfg_data[CUT_W-1:0]),
		.gains  (gains),
		.busy   (gain_busy)
	);

	assign s_axis_tready = !core_busy && !gain_busy;
	assign start         = s_axis_tvalid && s_axis_tready;

	ladf_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sample    (signed'(s_axis_tdata[SAMPLE_W-1:0])),
		.resonance (resonance_q),
		.gains     (gains),
		.busy      (core_busy),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: core hands off when the slot is empty or draining
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.bandpass, out_q.highpass, out_q.lowpass};

endmodule

`default_nettype wire
